/* rtl/core/imu_sfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sync frame parser package
// Shared constants and types for the sync-framed sample parser.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CfgSyncWord   = 1'b0;
  localparam cfg_idx_t CfgAccelCount = 1'b1;

  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned AccelCntW = 3;
  localparam int unsigned ChanOutW  = 3;
  localparam int unsigned ScaledW   = 23;
  localparam int unsigned RawW      = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned GyroShift = 8;

  // "DATF", first received byte in the top bits
  localparam logic [CfgDataW-1:0]  SyncReset  = 32'h4441_5446;
  localparam logic [AccelCntW-1:0] AccelReset = 3'd3;

  // 2048 / 16.4 * 256, rounded
  localparam logic signed [RawW-1:0] GyroMul = 16'sd31969;

  typedef logic [7:0]                hdr_byte_t;
  typedef logic signed [ScaledW-1:0] scaled_t;

endpackage

/* rtl/core/imu_sync_frame_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sync frame parser unit
// Hunts for a four-byte sync word in a byte stream, gathers little-endian
// 16-bit samples and scales them to signed values with 11 fractional bits.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one received byte per transaction on the input channel (in_valid_i,
//   in_stall_o, rx_byte_i). While hunting, the last four bytes are compared
//   with sync_word; on a match the next 2*SENSOR_COUNT bytes form the
//   packet payload. Every completed sample produces one output transaction
//   (channel_o, scaled_value_o, last_of_packet_o); bytes that finish no
//   sample produce none. After the last channel the hunt restarts.
//   Throughput: one byte per cycle, sustained while in_stall_o stays low.
//   Taking a sample's high byte loads the sample register; the scaled
//   value then moves on into the output register when the output is
//   ready.
//   Write sync_word and accel_count through cfg_we_i / cfg_idx_i /
//   cfg_data_i only while no transaction is in flight.
//   Reset: sync_word returns to "DATF", accel_count to 3, the parser hunts
//   with an empty header history and both pipeline stages are empty.
//   Stall: while out_stall_i holds a result, one more sample can wait in the
//   sample register; when that is full too, in_stall_o rises in the same
//   cycle and input bytes are held off until the output drains.
// ----------------------------------------------------------------------------
module imu_sync_frame_parser_unit #(
  parameter int unsigned SENSOR_COUNT = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  imu_sfp_pkg::cfg_idx_t               cfg_idx_i,
  input  logic [imu_sfp_pkg::CfgDataW-1:0]    cfg_data_i,
  // input byte channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          rx_byte_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [imu_sfp_pkg::ChanOutW-1:0]    channel_o,
  output imu_sfp_pkg::scaled_t                scaled_value_o,
  output logic                                last_of_packet_o
);

  localparam int unsigned CntW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned ExtW = CntW + imu_sfp_pkg::AccelCntW;
  localparam logic [CntW-1:0] LastChan = CntW'(SENSOR_COUNT - 1);

  // Configuration registers
  logic [imu_sfp_pkg::CfgDataW-1:0]  sync_word_q;
  logic [imu_sfp_pkg::AccelCntW-1:0] accel_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q   <= imu_sfp_pkg::SyncReset;
      accel_count_q <= imu_sfp_pkg::AccelReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imu_sfp_pkg::CfgSyncWord:   sync_word_q   <= cfg_data_i;
        imu_sfp_pkg::CfgAccelCount: accel_count_q <= cfg_data_i[imu_sfp_pkg::AccelCntW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline flow
  logic out_ready;
  logic s1_ready;
  logic in_fire;
  logic s1_valid_q;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  // Parser state
  logic [23:0]      hist_q, hist_d;
  logic [1:0]       hist_cnt_q, hist_cnt_d;
  logic             in_payload_q, in_payload_d;
  logic [CntW-1:0]  chan_q, chan_d;
  logic [7:0]       low_byte_q, low_byte_d;
  logic             high_phase_q, high_phase_d;

  logic [31:0]      hdr_word;
  logic             hdr_match;
  logic             sample_done;
  logic             is_last;
  logic [ExtW-1:0]  chan_ext;
  logic             is_accel;

  assign hdr_word    = {hist_q, rx_byte_i};
  assign hdr_match   = (hist_cnt_q == 2'd3) && (hdr_word == sync_word_q);
  assign sample_done = in_fire && in_payload_q && high_phase_q;
  assign is_last     = (chan_q == LastChan);
  assign chan_ext    = {{imu_sfp_pkg::AccelCntW{1'b0}}, chan_q};
  assign is_accel    = chan_ext < {{CntW{1'b0}}, accel_count_q};

  always_comb begin
    hist_d       = hist_q;
    hist_cnt_d   = hist_cnt_q;
    in_payload_d = in_payload_q;
    chan_d       = chan_q;
    low_byte_d   = low_byte_q;
    high_phase_d = high_phase_q;
    if (in_fire) begin
      if (!in_payload_q) begin
        if (hdr_match) begin
          // take the header; start gathering channel zero
          in_payload_d = 1'b1;
          hist_d       = '0;
          hist_cnt_d   = '0;
          chan_d       = '0;
          high_phase_d = 1'b0;
        end else begin
          hist_d = hdr_word[23:0];
          if (hist_cnt_q != 2'd3) begin
            hist_cnt_d = hist_cnt_q + 2'd1;
          end
        end
      end else if (!high_phase_q) begin
        low_byte_d   = rx_byte_i;
        high_phase_d = 1'b1;
      end else begin
        high_phase_d = 1'b0;
        if (is_last) begin
          // packet done: drop history and hunt again
          in_payload_d = 1'b0;
          chan_d       = '0;
          hist_d       = '0;
          hist_cnt_d   = '0;
        end else begin
          chan_d = chan_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q       <= '0;
      hist_cnt_q   <= '0;
      in_payload_q <= 1'b0;
      chan_q       <= '0;
      high_phase_q <= 1'b0;
    end else begin
      hist_q       <= hist_d;
      hist_cnt_q   <= hist_cnt_d;
      in_payload_q <= in_payload_d;
      chan_q       <= chan_d;
      high_phase_q <= high_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_byte_q <= low_byte_d;
  end

  // Sample register: raw sample with its channel tags
  logic signed [imu_sfp_pkg::RawW-1:0] s1_raw_q;
  logic [imu_sfp_pkg::ChanOutW-1:0]    s1_chan_q;
  logic [CntW-1:0]                     s1_cnt_q;
  logic                                s1_last_q;
  logic                                s1_accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= sample_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && sample_done) begin
      s1_raw_q   <= {rx_byte_i, low_byte_q};
      s1_chan_q  <= chan_ext[imu_sfp_pkg::ChanOutW-1:0];
      s1_cnt_q   <= chan_q;
      s1_last_q  <= is_last;
      s1_accel_q <= is_accel;
    end
  end

  // Scaling: accelerometer passes through, gyro is scaled by a constant
  // multiply and an arithmetic shift (floor)
  logic signed [imu_sfp_pkg::ProdW-1:0] gyro_prod;
  imu_sfp_pkg::scaled_t                 scaled_d;

  assign gyro_prod = s1_raw_q * imu_sfp_pkg::GyroMul;

  always_comb begin
    if (s1_accel_q) begin
      scaled_d = imu_sfp_pkg::ScaledW'(s1_raw_q);
    end else begin
      scaled_d = gyro_prod[imu_sfp_pkg::GyroShift +: imu_sfp_pkg::ScaledW];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      channel_o        <= s1_chan_q;
      scaled_value_o   <= scaled_d;
      last_of_packet_o <= s1_last_q;
    end
  end

  // Checks
  a_hist_clear_in_payload: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_payload_q |-> (hist_cnt_q == 2'd0)
  ) else $error("header history not cleared while gathering samples");

  a_high_phase_in_payload: assert property (
    @(posedge clk_i) disable iff (!rst_ni) high_phase_q |-> in_payload_q
  ) else $error("high byte phase outside of a packet");

  a_last_tag_channel: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && s1_last_q) |-> (s1_cnt_q == LastChan)
  ) else $error("last_of_packet on a channel other than the final one");

  a_sample_from_payload: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      sample_done |=> (s1_valid_q && (s1_last_q == !in_payload_q))
  ) else $error("sample register or packet end out of step with the parser");

  a_no_loss_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && out_valid_o && out_stall_i) |=> s1_valid_q
  ) else $error("waiting sample dropped while output stalled");

endmodule

/* bench/imu_sfp_sample_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sync frame parser sample checker
// Watches both channels and the register port, predicts the scaled samples
// from the accepted bytes and compares every output transaction in order.
// ----------------------------------------------------------------------------
module imu_sfp_sample_checker
  import imu_sfp_pkg::*;
#(
  parameter int unsigned SENSOR_COUNT = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  cfg_idx_t             cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ChanOutW-1:0]  channel_i,
  input  scaled_t              scaled_value_i,
  input  logic                 last_of_packet_i,
  output int unsigned          mismatch_o,
  output int unsigned          pending_o,
  output int unsigned          samples_o
);

  localparam int unsigned MaxReports = 10;
  // 2048 / 16.4 in 8 fractional bits
  localparam longint GyroGain = 31969;

  typedef struct packed {
    logic [ChanOutW-1:0] chan;
    scaled_t             value;
    logic                last;
  } sample_t;

  sample_t expected_samples[$];

  // shadow registers
  logic [CfgDataW-1:0]  sync_q;
  logic [AccelCntW-1:0] accel_q;

  // parser shadow state
  logic [23:0] hdr_hist;
  int unsigned hist_cnt;
  logic        in_frame;
  int unsigned chan_cnt;
  logic [7:0]  low_q;
  logic        hi_phase;

  // Advance the parser by one byte; return 1 when a sample completes.
  function automatic bit parse_rx_byte(input logic [7:0] b, output sample_t s);
    logic [31:0]        word;
    logic signed [15:0] raw;
    longint             prod;
    s = '0;
    if (!in_frame) begin
      word = {hdr_hist, b};
      if (hist_cnt >= 3 && word == sync_q) begin
        in_frame = 1'b1;
        hdr_hist = '0;
        hist_cnt = 0;
        chan_cnt = 0;
        hi_phase = 1'b0;
        low_q    = '0;
      end else begin
        hdr_hist = word[23:0];
        if (hist_cnt < 3) hist_cnt++;
      end
      return 1'b0;
    end
    if (!hi_phase) begin
      low_q    = b;
      hi_phase = 1'b1;
      return 1'b0;
    end
    raw    = {b, low_q};
    s.chan = chan_cnt[ChanOutW-1:0];
    if (chan_cnt < accel_q) begin
      s.value = scaled_t'(raw);
    end else begin
      // arithmetic shift floors toward minus infinity
      prod    = longint'(raw) * GyroGain;
      s.value = scaled_t'(prod >>> 8);
    end
    s.last   = (chan_cnt + 1 >= SENSOR_COUNT);
    hi_phase = 1'b0;
    low_q    = '0;
    if (s.last) begin
      in_frame = 1'b0;
      chan_cnt = 0;
      hdr_hist = '0;
      hist_cnt = 0;
    end else begin
      chan_cnt++;
    end
    return 1'b1;
  endfunction

  task automatic note_error(input string msg);
    if (mismatch_o < MaxReports) $display("%0t: %s", $realtime, msg);
    mismatch_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sample_t got;
    sample_t want;
    sample_t fresh;
    if (!rst_ni) begin
      sync_q     = SyncReset;
      accel_q    = AccelReset;
      hdr_hist   = '0;
      hist_cnt   = 0;
      in_frame   = 1'b0;
      chan_cnt   = 0;
      low_q      = '0;
      hi_phase   = 1'b0;
      expected_samples.delete();
      mismatch_o = 0;
      samples_o  = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSyncWord:   sync_q  = cfg_data_i;
          CfgAccelCount: accel_q = cfg_data_i[AccelCntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{chan: channel_i, value: scaled_value_i, last: last_of_packet_i};
        samples_o++;
        if (expected_samples.size() == 0) begin
          note_error($sformatf("unexpected sample: chan %0d value %0d last %0b",
                               got.chan, got.value, got.last));
        end else begin
          want = expected_samples.pop_front();
          if (got.chan !== want.chan || got.value !== want.value ||
              got.last !== want.last) begin
            note_error($sformatf(
              "sample mismatch: expected chan %0d value %0d last %0b, got %0d %0d %0b",
              want.chan, want.value, want.last, got.chan, got.value, got.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (parse_rx_byte(rx_byte_i, fresh)) begin
          expected_samples.insert(expected_samples.size(), fresh);
        end
      end
      pending_o <= expected_samples.size();
    end
  end

endmodule

/* bench/imu_sync_frame_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sync frame parser unit testbench
// Feeds framed and broken byte streams under several register settings with
// random gaps on both channels; a separate checker predicts each sample.
// ----------------------------------------------------------------------------
module imu_sync_frame_parser_unit_tb;
  import imu_sfp_pkg::*;

  localparam int unsigned SensorCount  = 6;
  localparam int unsigned FrameBytes   = 2 * SensorCount;
  // bytes offered across the random phases
  localparam int unsigned RandomBytes  = 1400;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned ChokeCycles  = 300;
  // settle margin after the last predicted result has come out
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 200000;

  // block inputs, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  cfg_idx_t            cfg_idx_i   = CfgSyncWord;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_stall_i = 1'b0;

  // block outputs
  logic                in_stall_o;
  logic                out_valid_o;
  logic [ChanOutW-1:0] channel_o;
  scaled_t             scaled_value_o;
  logic                last_of_packet_o;

  // checker status
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned sample_cnt;

  // run bookkeeping
  int unsigned cycle_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;

  // idle switches: when clear that side runs back to back
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  // request for one long output hold-off
  bit choke_req  = 1'b0;

  always #1 clk_i = ~clk_i;

  imu_sync_frame_parser_unit #(
    .SENSOR_COUNT(SensorCount)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_o       (channel_o),
    .scaled_value_o  (scaled_value_o),
    .last_of_packet_o(last_of_packet_o)
  );

  imu_sfp_sample_checker #(
    .SENSOR_COUNT(SensorCount)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_i       (channel_o),
    .scaled_value_i  (scaled_value_o),
    .last_of_packet_i(last_of_packet_o),
    .mismatch_o      (mismatch_cnt),
    .pending_o       (pending_cnt),
    .samples_o       (sample_cnt)
  );

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("imu_sync_frame_parser_unit_tb: errors");
      $finish;
    end
  end

  // Result side: draw a fresh stall length after every accepted sample, and
  // serve a long hold-off when asked. Exactly one assignment per edge.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) begin
          if ($urandom_range(0, 31) == 0) rx_idle_on = ~rx_idle_on;
          stall_left = rx_idle_on ? $urandom_range(0, 7) : 0;
        end
        if (choke_req) begin
          stall_left = ChokeCycles;
          choke_req  = 1'b0;
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one byte after a random gap and hold it until taken.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // Send the four sync bytes, first byte from the top, then the payload
  // low byte first per sample.
  task automatic push_frame(input logic [31:0] sw,
                            input logic [8*FrameBytes-1:0] body);
    for (int j = 0; j < 4; j++) push_byte(sw[31-8*j -: 8]);
    for (int k = 0; k < FrameBytes; k++) push_byte(body[8*k +: 8]);
    frames_sent++;
  endtask

  // Lower valid, then wait until every predicted sample has come out and the
  // pipeline has had time to settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the sync word, then the accel count; call only when drained.
  task automatic load_regs(input logic [31:0] sw, input logic [AccelCntW-1:0] acc);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSyncWord;
    cfg_data_i <= sw;
    @(posedge clk_i);
    cfg_idx_i  <= CfgAccelCount;
    cfg_data_i <= CfgDataW'(acc);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Bias toward the sample extremes and the gyro rounding corner.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [8*FrameBytes-1:0] body;
    logic [31:0]             sw;
    logic [AccelCntW-1:0]    acc;
    logic [7:0]              rep;
    int unsigned             phase_quota;
    int unsigned             phase_start;
    int unsigned             spot;
    int unsigned             n;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two stray bytes, then one frame under the reset registers.
    // Channels 0..2 scale as accel, 3..5 as gyro; each group sees the most
    // negative, most positive and minus-one samples, the last one checking
    // floor rounding on the gyro side.
    tx_idle_on = 1'b0;
    push_byte("D");
    push_byte("A");
    body = {16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000};
    push_frame(SyncReset, body);
    tx_idle_on = 1'b1;
    drain();

    // Random phases, each under its own register setting.
    phase_quota = RandomBytes / NumPhases;
    for (int p = 0; p < NumPhases; p++) begin
      rep = 8'($urandom);
      case (p)
        0:       begin sw = SyncReset;         acc = 3'd0; end
        1:       begin sw = 32'h0000_0000;     acc = 3'd7; end
        2:       begin sw = 32'hFFFF_FFFF;     acc = 3'd6; end
        3:       begin sw = {4{rep}};          acc = 3'd1; end
        4:       begin sw = $urandom;          acc = 3'd2; end
        5:       begin sw = $urandom;          acc = 3'd5; end
        6:       begin sw = $urandom;          acc = 3'd4; end
        default: begin sw = SyncReset;         acc = AccelReset; end
      endcase
      load_regs(sw, acc);

      // Hold the output for a long stretch while bytes keep coming, so the
      // block fills and stalls its input.
      if (p == 3) choke_req = 1'b1;

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < phase_quota) begin
        if ($urandom_range(0, 15) == 0) tx_idle_on = ~tx_idle_on;
        case ($urandom_range(0, 9))
          7: begin
            // partial header, then a stray byte
            n = $urandom_range(1, 3);
            for (int j = 0; j < n; j++) push_byte(sw[31-8*j -: 8]);
            push_byte(8'($urandom));
          end
          8: begin
            // header followed by a cut-short payload; the bytes that follow,
            // such as the next frame's header, get swallowed as payload
            n = $urandom_range(1, FrameBytes - 1);
            for (int j = 0; j < 4; j++) push_byte(sw[31-8*j -: 8]);
            for (int k = 0; k < n; k++) push_byte(8'($urandom));
          end
          9: begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) push_byte(8'($urandom));
          end
          default: begin
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) push_byte(8'($urandom));
            for (int c = 0; c < SensorCount; c++) body[16*c +: 16] = pick_sample();
            // sometimes plant the sync word inside the payload; it must pass
            // through as sample data
            if ($urandom_range(0, 7) == 0) begin
              spot = $urandom_range(0, FrameBytes - 4);
              for (int j = 0; j < 4; j++) body[8*(spot+j) +: 8] = sw[31-8*j -: 8];
            end
            push_frame(sw, body);
          end
        endcase
      end
      drain();
    end

    $display("Run covered %0d bytes in %0d frames over %0d register settings,",
             bytes_sent, frames_sent, NumPhases + 1);
    $display("with %0d samples compared and %0d mismatches.", sample_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("imu_sync_frame_parser_unit_tb: clean");
    end else begin
      $display("imu_sync_frame_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* imu_sync_frame_parser_unit.f */
rtl/core/imu_sfp_pkg.sv
rtl/core/imu_sync_frame_parser_unit.sv
bench/imu_sfp_sample_checker.sv
bench/imu_sync_frame_parser_unit_tb.sv
